### sv/mexp_pkg.sv
// Shared widths, constants, types and the modular add helper for the
// modular exponentiation block. Depends on nothing.

package mexp_pkg;

   // Field widths.
   localparam int MOD_WIDTH  = 31;
   localparam int BASE_WIDTH = 32;
   localparam int EXP_WIDTH  = 63;

   // Counter widths for the base reduction and for one modular product.
   localparam int RED_COUNT_WIDTH = $clog2(BASE_WIDTH + 1);
   localparam int MUL_COUNT_WIDTH = $clog2(MOD_WIDTH + 1);

   // Modulus after reset (the prime 1e9 + 7).
   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_WAIT,
      ST_FINISH
   } state_type;

   // (a + b) mod m for a, b below m: one add and one conditional subtract.
   function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] a,
                                                    input logic [MOD_WIDTH-1:0] b,
                                                    input logic [MOD_WIDTH-1:0] m);
      logic [MOD_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[MOD_WIDTH-1:0];
   endfunction

endpackage

### sv/mexp_modmul.sv
// Bit-serial modular multiplier: x * y mod m by shift-and-add, one bit of y
// per cycle. Depends on mexp_pkg for widths and add_mod.

module mexp_modmul import mexp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MOD_WIDTH-1:0] x,
   input  logic [MOD_WIDTH-1:0] y,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] product
);

   logic [MUL_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       done_ff, done_in;
   logic [MOD_WIDTH-1:0]       acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]       x_ff, x_in;
   logic [MOD_WIDTH-1:0]       y_ff, y_in;

   // Each busy cycle adds the multiplicand when the low bit of y is set, then
   // doubles the multiplicand and shifts y right by one.
   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (start) begin
         count_in = MUL_COUNT_WIDTH'(MOD_WIDTH);
         acc_in   = '0;
         x_in     = x;
         y_in     = y;
      end else if (count_ff != '0) begin
         if (y_ff[0]) begin
            acc_in = add_mod(acc_ff, x_ff, modulus);
         end
         x_in     = add_mod(x_ff, x_ff, modulus);
         y_in     = {1'b0, y_ff[MOD_WIDTH-1:1]};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == MUL_COUNT_WIDTH'(1));
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Operand shift registers and accumulator.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer, base reduction
// and two mexp_modmul instances. Depends on mexp_pkg and mexp_modmul.

// A word carries a base and an exponent; the block returns base to the power
// exponent modulo the csr modulus (a modulus below 2 gives 0, a zero exponent
// gives 1). One word is worked on at a time. The base is first reduced by a
// restoring shift-subtract over its 32 bits. The exponent is then scanned
// from its low bit; each scanned bit costs one pass of the two bit-serial
// multipliers, which form the result product and the square side by side.
// Scanning stops at the highest set exponent bit. A finished word waits in
// the output register while the next word is accepted. The modulus may only
// be written while idle.

module modular_exponentiation import mexp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [MOD_WIDTH-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BASE_WIDTH-1:0] req_base,
   input  logic [EXP_WIDTH-1:0] req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MOD_WIDTH-1:0] rsp_power
);

   state_type                  state_ff, state_in;
   logic [MOD_WIDTH-1:0]       modulus_ff;
   logic [RED_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [BASE_WIDTH-1:0]      base_ff, base_in;
   logic [EXP_WIDTH-1:0]       exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]       sq_ff, sq_in;
   logic [MOD_WIDTH-1:0]       res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0]       power_ff, power_in;
   logic                       mul_start;
   logic                       res_done, sq_done;
   logic [MOD_WIDTH-1:0]       res_product, sq_product;
   logic [MOD_WIDTH:0]         rem_shift;

   // Result product and square run together on the same old square.
   mexp_modmul u_res_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (res_ff),
      .y       (sq_ff),
      .modulus (modulus_ff),
      .done    (res_done),
      .product (res_product)
   );

   mexp_modmul u_sq_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (sq_ff),
      .y       (sq_ff),
      .modulus (modulus_ff),
      .done    (sq_done),
      .product (sq_product)
   );

   // One restoring reduction step: shift in the next base bit.
   assign rem_shift = {sq_ff, base_ff[BASE_WIDTH-1]};

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      mul_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      power_in     = power_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in  = req_base;
               exp_in   = req_exponent;
               sq_in    = '0;
               count_in = RED_COUNT_WIDTH'(BASE_WIDTH);
               res_in   = MOD_WIDTH'(1);
               if (modulus_ff < MOD_WIDTH'(2)) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (rem_shift >= {1'b0, modulus_ff}) begin
               sq_in = MOD_WIDTH'(rem_shift - {1'b0, modulus_ff});
            end else begin
               sq_in = rem_shift[MOD_WIDTH-1:0];
            end
            base_in  = {base_ff[BASE_WIDTH-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == RED_COUNT_WIDTH'(1)) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (res_done && sq_done) begin
               sq_in = sq_product;
               if (exp_ff[0]) begin
                  res_in = res_product;
               end
               exp_in   = {1'b0, exp_ff[EXP_WIDTH-1:1]};
               state_in = ST_MULT;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               power_in     = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the modulus register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_write_enable) begin
            modulus_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      sq_ff    <= sq_in;
      res_ff   <= res_in;
      power_ff <= power_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = power_ff;

endmodule
